// ----- rtl/trd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types for the tile run-length decoder.
// No dependencies; imported by the core, the sequencer and the datapath.
package trd_pkg;

  localparam int unsigned TILE_BYTES  = 16;
  localparam int unsigned FILL_W      = (TILE_BYTES > 2) ? $clog2(TILE_BYTES) : 1;
  localparam int unsigned SKIP_W      = $clog2(255 * TILE_BYTES + 1);
  localparam int unsigned MAX_RESULTS = 33;
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned CHUNK_BYTES = 4;

  // decode phases
  localparam logic [1:0] PH_CMD = 2'd0;
  localparam logic [1:0] PH_OP1 = 2'd1;
  localparam logic [1:0] PH_OP2 = 2'd2;
  localparam logic [1:0] PH_LIT = 2'd3;

  // value generator kinds
  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_INC  = 3'd1;
  localparam logic [2:0] K_RUN  = 3'd2;
  localparam logic [2:0] K_INV  = 3'd3;
  localparam logic [2:0] K_ROW  = 3'd4;
  localparam logic [2:0] K_ALT  = 3'd5;
  localparam logic [2:0] K_LIT  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_FIRST_TILE  = 2'd0;
  localparam logic [1:0] CFG_TILES_WRITE = 2'd1;
  localparam logic [1:0] CFG_TILES_SKIP  = 2'd2;

  // command byte constants
  localparam logic [7:0] CMD_END      = 8'h00;
  localparam logic [7:0] CMD_LIT_BASE = 8'h10;
  localparam logic [6:0] LIT_BIAS     = 7'd15;
  localparam logic [7:0] BYTE_ONES    = 8'hFF;

  typedef struct packed {
    logic [CHUNK_BYTES-1:0][7:0] bytes;
    logic [2:0]                  cnt;
    logic [7:0]                  tile;
    logic                        commit;
    logic                        done;
  } chunk_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic step;
    logic flush_close;
    logic flush_last;
  } dp_cmd_t;

  typedef struct packed {
    logic dec_work;
    logic dec_marker;
    logic busy;
    logic ch_open;
    logic held_valid;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/tile_rle_decoder_core.sv -----
`timescale 1ns / 1ps
// Tile run-length decoder. A byte is taken in the idle state and decoded in the
// next cycle. An expanding byte then gives one decoded byte or one chunk close
// per step, then a flush of the open and held chunks; the expander holds
// whenever the output register is stalled. Reset clears the configuration to
// zero, restarts the stream, empties output.
module tile_rle_decoder_core import trd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] code_byte_i,
  input  logic       frame_start_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_0_o,
  output logic [7:0] out_byte_1_o,
  output logic [7:0] out_byte_2_o,
  output logic [7:0] out_byte_3_o,
  output logic [2:0] byte_count_o,
  output logic [7:0] tile_number_o,
  output logic       tile_commit_o,
  output logic       stream_done_o,
  output logic       last_of_run_o
);

  dp_cmd_t    cmd;
  dp_status_t st;
  chunk_t     out_chunk;

  trd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  trd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .code_byte_i   (code_byte_i),
    .frame_start_i (frame_start_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_chunk_o   (out_chunk),
    .out_last_o    (last_of_run_o)
  );

  assign out_byte_0_o  = out_chunk.bytes[0];
  assign out_byte_1_o  = out_chunk.bytes[1];
  assign out_byte_2_o  = out_chunk.bytes[2];
  assign out_byte_3_o  = out_chunk.bytes[3];
  assign byte_count_o  = out_chunk.cnt;
  assign tile_number_o = out_chunk.tile;
  assign tile_commit_o = out_chunk.commit;
  assign stream_done_o = out_chunk.done;

endmodule

// ----- rtl/trd_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the tile run-length decoder: accept, decode, expand, flush.
// Depends on trd_pkg for the command and status structs.
module trd_ctrl import trd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t st_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_RUN    = 2'd2;
  localparam logic [1:0] S_FLUSH  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (st_i.dec_work) begin
          state_d = S_RUN;
        end else if (st_i.dec_marker) begin
          state_d = S_FLUSH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RUN: begin
        if (!st_i.busy) begin
          state_d = S_FLUSH;
        end else if (st_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      S_FLUSH: begin
        // close the open chunk first, then release the held one marked last
        if (st_i.ch_open) begin
          if (st_i.out_free) begin
            cmd_o.flush_close = 1'b1;
          end
        end else if (st_i.held_valid) begin
          if (st_i.out_free) begin
            cmd_o.flush_last = 1'b1;
            state_d          = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/trd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the tile run-length decoder: config registers, stream state,
// value generator, chunk assembly, one held chunk and the output register.
// Depends on trd_pkg.
module trd_datapath import trd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t st_o,
  input  logic [7:0] code_byte_i,
  input  logic       frame_start_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output chunk_t     out_chunk_o,
  output logic       out_last_o
);

  // configuration
  logic [7:0] base_tile_q, base_tile_d;
  logic [7:0] tiles_write_q, tiles_write_d;
  logic [7:0] tiles_skip_q, tiles_skip_d;

  // stream state
  logic [7:0]        code_q, code_d;
  logic [1:0]        phase_q, phase_d;
  logic [2:0]        kind_q, kind_d;
  logic [6:0]        plen_q, plen_d;
  logic [7:0]        first_q, first_d;
  logic [7:0]        second_q, second_d;
  logic              mono_q, mono_d;
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [7:0]        left_q, left_d;
  logic [7:0]        tile_q, tile_d;
  logic              halted_q, halted_d;

  // value generator
  logic [2:0] exp_kind_q, exp_kind_d;
  logic [6:0] vcnt_q, vcnt_d;
  logic       dup_q, dup_d;
  logic [7:0] val_q, val_d;

  // chunk assembly, held chunk, output
  chunk_t           ch_q, ch_d;
  logic             ch_open_q, ch_open_d;
  chunk_t           held_q, held_d;
  logic             held_v_q, held_v_d;
  logic [RES_W-1:0] res_cnt_q, res_cnt_d;
  chunk_t           out_q, out_d;
  logic             out_last_q, out_last_d;
  logic             out_valid_q, out_valid_d;

  // combinational helpers
  logic       restart;
  logic       start_exp;
  logic [6:0] exp_count;
  logic [2:0] exp_kind_sel;
  logic [6:0] plen_next;
  logic       dec_work, dec_marker;
  logic [7:0] b_val;
  logic       completes;
  chunk_t     cw;
  chunk_t     close_c;
  logic       close_req;
  logic       push, push_last;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    base_tile_d   = base_tile_q;
    tiles_write_d = tiles_write_q;
    tiles_skip_d  = tiles_skip_q;
    code_d        = code_q;
    phase_d       = phase_q;
    kind_d        = kind_q;
    plen_d        = plen_q;
    first_d       = first_q;
    second_d      = second_q;
    mono_d        = mono_q;
    skip_d        = skip_q;
    fill_d        = fill_q;
    left_d        = left_q;
    tile_d        = tile_q;
    halted_d      = halted_q;
    exp_kind_d    = exp_kind_q;
    vcnt_d        = vcnt_q;
    dup_d         = dup_q;
    val_d         = val_q;
    ch_d          = ch_q;
    ch_open_d     = ch_open_q;
    held_d        = held_q;
    held_v_d      = held_v_q;
    res_cnt_d     = res_cnt_q;
    out_d         = out_q;
    out_last_d    = out_last_q;
    out_valid_d   = out_valid_q && out_stall_i;

    restart      = 1'b0;
    start_exp    = 1'b0;
    exp_count    = '0;
    exp_kind_sel = kind_q;
    plen_next    = plen_q;
    dec_work     = 1'b0;
    dec_marker   = 1'b0;
    b_val        = first_q;
    completes    = (fill_q == FILL_W'(TILE_BYTES - 1));
    cw           = ch_q;
    close_c      = ch_q;
    close_req    = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;

    // writes to the three configuration registers restart the stream
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIRST_TILE: begin
          base_tile_d = cfg_data_i;
          restart     = 1'b1;
        end
        CFG_TILES_WRITE: begin
          tiles_write_d = cfg_data_i;
          restart       = 1'b1;
        end
        CFG_TILES_SKIP: begin
          tiles_skip_d = cfg_data_i;
          restart      = 1'b1;
        end
        default: ;
      endcase
    end

    if (cmd_i.capture) begin
      code_d = code_byte_i;
      if (frame_start_i) begin
        restart = 1'b1;
      end
    end

    if (restart) begin
      phase_d  = PH_CMD;
      kind_d   = K_NONE;
      plen_d   = '0;
      first_d  = '0;
      second_d = '0;
      mono_d   = 1'b0;
      halted_d = 1'b0;
      skip_d   = SKIP_W'(tiles_skip_d) * SKIP_W'(TILE_BYTES);
      fill_d   = '0;
      left_d   = tiles_write_d;
      tile_d   = base_tile_d;
      vcnt_d   = '0;
      dup_d    = 1'b0;
    end

    // decode of the captured byte
    if (cmd_i.decode) begin
      ch_open_d = 1'b0;
      held_v_d  = 1'b0;
      res_cnt_d = '0;
      dup_d     = 1'b0;
      vcnt_d    = '0;
      if (!halted_q) begin
        unique case (phase_q)
          PH_CMD: begin
            if (code_q == CMD_END) begin
              // end of data: marker-only chunk goes straight to the held slot
              held_d     = '{bytes: '0, cnt: 3'd0, tile: tile_q, commit: 1'b0,
                             done: 1'b1};
              held_v_d   = 1'b1;
              res_cnt_d  = RES_W'(1);
              halted_d   = 1'b1;
              dec_marker = 1'b1;
            end else if (!code_q[7]) begin
              if (code_q < CMD_LIT_BASE) begin
                kind_d  = K_INC;
                plen_d  = 7'(code_q[3:0]) + 7'd1;
                phase_d = PH_OP1;
              end else begin
                plen_d  = code_q[6:0] - LIT_BIAS;
                phase_d = PH_LIT;
              end
            end else if (code_q[6:0] == 7'd0) begin
              mono_d = !mono_q;
              skip_d = mono_q ? (skip_q << 1) : (skip_q >> 1);
            end else if (!code_q[6]) begin
              if (!code_q[5]) begin
                kind_d  = K_RUN;
                plen_d  = 7'(code_q[4:0]) + 7'd1;
                phase_d = PH_OP1;
              end else begin
                kind_d       = K_ROW;
                first_d      = code_q[4] ? 8'h00 : BYTE_ONES;
                second_d     = code_q[0] ? 8'h00 : BYTE_ONES;
                start_exp    = 1'b1;
                exp_count    = 7'({code_q[3:1], 1'b0}) + 7'd2;
                exp_kind_sel = K_ROW;
              end
            end else begin
              kind_d  = code_q[0] ? K_ALT : K_INV;
              plen_d  = 7'({code_q[5:1], 1'b0}) + 7'd4;
              phase_d = PH_OP1;
            end
          end
          PH_OP1: begin
            first_d = code_q;
            if (kind_q == K_ALT) begin
              phase_d = PH_OP2;
            end else begin
              second_d  = (kind_q == K_INV) ? ~code_q : code_q;
              phase_d   = PH_CMD;
              start_exp = 1'b1;
              exp_count = plen_q;
            end
          end
          PH_OP2: begin
            second_d  = code_q;
            phase_d   = PH_CMD;
            start_exp = 1'b1;
            exp_count = plen_q;
          end
          PH_LIT: begin
            if (skip_q != '0) begin
              skip_d = skip_q - SKIP_W'(1);
            end else begin
              vcnt_d     = 7'd1;
              exp_kind_d = K_LIT;
              val_d      = code_q;
              dec_work   = 1'b1;
            end
            plen_next = (plen_q != 7'd0) ? plen_q - 7'd1 : plen_q;
            plen_d    = plen_next;
            if (plen_next == 7'd0) begin
              phase_d = PH_CMD;
            end
          end
        endcase

        // the skip is taken off the front of a run
        if (start_exp) begin
          exp_kind_d = exp_kind_sel;
          if (SKIP_W'(exp_count) < skip_q) begin
            skip_d = skip_q - SKIP_W'(exp_count);
            vcnt_d = '0;
          end else begin
            skip_d   = '0;
            vcnt_d   = exp_count - 7'(skip_q);
            dec_work = (exp_count != 7'(skip_q));
          end
        end
      end
    end

    // one decoded byte, or one chunk close, per step
    if (cmd_i.step) begin
      if (dup_q) begin
        b_val = val_q;
      end else begin
        unique case (exp_kind_q)
          K_INC:   b_val = first_q;
          K_LIT:   b_val = val_q;
          default: b_val = vcnt_q[0] ? second_q : first_q;
        endcase
      end

      if (ch_open_q && (ch_q.cnt == 3'(CHUNK_BYTES) || (ch_q.commit && completes))) begin
        close_req = 1'b1;
        close_c   = ch_q;
        ch_open_d = 1'b0;
      end else begin
        if (!ch_open_q) begin
          cw = '{bytes: '0, cnt: 3'd0, tile: tile_q, commit: 1'b0, done: 1'b0};
        end
        cw.bytes[cw.cnt[1:0]] = b_val;
        cw.cnt                = cw.cnt + 3'd1;

        if (dup_q) begin
          dup_d = 1'b0;
        end else begin
          vcnt_d = vcnt_q - 7'd1;
          if (exp_kind_q == K_INC) begin
            first_d = first_q + 8'd1;
          end
          if (mono_q) begin
            dup_d = 1'b1;
            val_d = b_val;
          end
        end

        if (completes) begin
          fill_d = '0;
          if (left_q == 8'd0) begin
            // zero tiles to write: first full tile stops without a commit
            halted_d  = 1'b1;
            cw.done   = 1'b1;
            close_req = 1'b1;
          end else begin
            cw.commit = 1'b1;
            tile_d    = tile_q + 8'd1;
            left_d    = left_q - 8'd1;
            if (left_q == 8'd1) begin
              halted_d  = 1'b1;
              cw.done   = 1'b1;
              close_req = 1'b1;
            end
          end
        end else begin
          fill_d = fill_q + FILL_W'(1);
        end

        if (close_req) begin
          close_c   = cw;
          ch_open_d = 1'b0;
        end else begin
          ch_d      = cw;
          ch_open_d = 1'b1;
        end
      end
    end

    if (cmd_i.flush_close) begin
      close_req = 1'b1;
      close_c   = ch_q;
      ch_open_d = 1'b0;
    end

    if (cmd_i.flush_last) begin
      push      = 1'b1;
      push_last = 1'b1;
      held_v_d  = 1'b0;
    end

    // a closed chunk waits in the held slot until we know whether it is last
    if (close_req && (res_cnt_q < RES_W'(MAX_RESULTS))) begin
      if (held_v_q) begin
        push = 1'b1;
      end
      held_d    = close_c;
      held_v_d  = 1'b1;
      res_cnt_d = res_cnt_q + RES_W'(1);
    end

    if (push) begin
      out_d       = held_q;
      out_last_d  = push_last;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_tile_q   <= '0;
      tiles_write_q <= '0;
      tiles_skip_q  <= '0;
      phase_q       <= PH_CMD;
      kind_q        <= K_NONE;
      plen_q        <= '0;
      mono_q        <= 1'b0;
      skip_q        <= '0;
      fill_q        <= '0;
      left_q        <= '0;
      tile_q        <= '0;
      halted_q      <= 1'b0;
      exp_kind_q    <= K_NONE;
      vcnt_q        <= '0;
      dup_q         <= 1'b0;
      ch_open_q     <= 1'b0;
      held_v_q      <= 1'b0;
      res_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      base_tile_q   <= base_tile_d;
      tiles_write_q <= tiles_write_d;
      tiles_skip_q  <= tiles_skip_d;
      phase_q       <= phase_d;
      kind_q        <= kind_d;
      plen_q        <= plen_d;
      mono_q        <= mono_d;
      skip_q        <= skip_d;
      fill_q        <= fill_d;
      left_q        <= left_d;
      tile_q        <= tile_d;
      halted_q      <= halted_d;
      exp_kind_q    <= exp_kind_d;
      vcnt_q        <= vcnt_d;
      dup_q         <= dup_d;
      ch_open_q     <= ch_open_d;
      held_v_q      <= held_v_d;
      res_cnt_q     <= res_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    first_q    <= first_d;
    second_q   <= second_d;
    val_q      <= val_d;
    ch_q       <= ch_d;
    held_q     <= held_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign st_o.dec_work   = dec_work;
  assign st_o.dec_marker = dec_marker;
  assign st_o.busy       = !halted_q && (dup_q || (vcnt_q != 7'd0));
  assign st_o.ch_open    = ch_open_q;
  assign st_o.held_valid = held_v_q;
  assign st_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_chunk_o = out_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/trd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the tile run-length decoder, bound to the top level.
// Depends only on the top level's ports.
module trd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_0_o,
  input logic [7:0] out_byte_3_o,
  input logic [2:0] byte_count_o,
  input logic       tile_commit_o,
  input logic       stream_done_o,
  input logic       last_of_run_o
);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o <= 3'd4)
    else $error("chunk byte count above four");

  // an empty chunk is only the end-of-data marker
  a_marker_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o == 3'd0 |-> stream_done_o && last_of_run_o && !tile_commit_o)
    else $error("empty chunk that is not a lone stop marker");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_done_o |-> last_of_run_o)
    else $error("chunk after a stop");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o != 3'd4 |-> out_byte_3_o == 8'h00)
    else $error("unused chunk byte not zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_count_o)
      && $stable(out_byte_0_o))
    else $error("stalled chunk changed");

endmodule

bind tile_rle_decoder_core trd_checker u_trd_checker (.*);
